// ===== rtl/core/tga_rle_pixel_decoder_core_assert.svh =====
// Assertion macros for the Targa run-length pixel decoder core.
// Used by the modules that carry concurrent checks; needs clk_i and rst_ni in scope.
`ifndef TGA_RLE_PIXEL_DECODER_CORE_ASSERT_SVH
`define TGA_RLE_PIXEL_DECODER_CORE_ASSERT_SVH

// Same-cycle implication, disabled during reset
`define TGA_RLE_ASSERT_IMP(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset
`define TGA_RLE_ASSERT_NXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/core/tga_rle_pkg.sv =====
// Shared types and constants of the Targa run-length pixel decoder core.
// No dependencies; used by all core modules and the testbench.
package tga_rle_pkg;

  // Run queue between front and back
  localparam int unsigned QueueDepth = 2;
  localparam int unsigned QPtrW      = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
  localparam int unsigned QCntW      = $clog2(QueueDepth + 1);

  // One run yields at most this many line pieces (line width of at least 3)
  localparam int unsigned MaxChunks   = 44;
  // Rows that all runs in flight can consume at most
  localparam int unsigned NearEndRows = (QueueDepth + 1) * MaxChunks;

  // Register indexes
  localparam logic [1:0] RegDepthMode = 2'd0;
  localparam logic [1:0] RegRunCoded  = 2'd1;
  localparam logic [1:0] RegLineWidth = 2'd2;
  localparam logic [1:0] RegLineTotal = 2'd3;

  typedef enum logic [1:0] {
    Depth8  = 2'd0,
    Depth16 = 2'd1,
    Depth24 = 2'd2,
    Depth32 = 2'd3
  } depth_e;

  typedef struct packed {
    depth_e      depth_mode;
    logic        run_coded;
    logic [15:0] line_width;
    logic [15:0] line_total;
  } cfg_t;

  localparam cfg_t CfgReset = '{
    depth_mode: Depth24,
    run_coded:  1'b0,
    line_width: 16'd640,
    line_total: 16'd480
  };

  // One decoded pixel run waiting for line splitting
  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [7:0] index_value;
    logic [7:0] count;
  } run_t;

  // Back end status seen by the front end
  typedef struct packed {
    logic busy;      // run queued or in progress
    logic done;      // all lines delivered
    logic near_end;  // runs in flight might reach the image end
  } back_status_t;

endpackage

// ===== rtl/core/tga_rle_if.sv =====
// Valid/ready channel interfaces of the Targa run-length pixel decoder core.
// No dependencies.
interface tga_rle_in_if;
  logic       valid;
  logic       ready;
  logic       func;
  logic [7:0] data_byte;

  modport source (output valid, output func, output data_byte, input ready);
  modport sink   (input valid, input func, input data_byte, output ready);
endinterface

interface tga_rle_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] red;
  logic [7:0] green;
  logic [7:0] blue;
  logic [7:0] index_value;
  logic [7:0] repeat_count;
  logic       end_of_line;
  logic       end_of_image;
  logic       last;

  modport source (output valid, output red, output green, output blue, output index_value,
                  output repeat_count, output end_of_line, output end_of_image, output last,
                  input ready);
  modport sink   (input valid, input red, input green, input blue, input index_value,
                  input repeat_count, input end_of_line, input end_of_image, input last,
                  output ready);
endinterface

// ===== rtl/core/tga_rle_front.sv =====
// Front end: takes file bytes, tracks packet and pixel assembly, pushes pixel runs.
// Depends on tga_rle_pkg and tga_rle_in_if.
module tga_rle_front (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  tga_rle_pkg::cfg_t          cfg_i,
  input  tga_rle_pkg::back_status_t  status_i,
  input  logic                       full_i,
  tga_rle_in_if.sink                 in_i,
  output logic                       push_o,
  output tga_rle_pkg::run_t          run_o,
  output logic                       restart_o
);

  logic        hdr_q, hdr_d;
  logic        is_run_q, is_run_d;
  logic [7:0]  left_q, left_d;
  logic [1:0]  bip_q, bip_d;
  logic [23:0] pb_q, pb_d;

  logic        accept;
  logic        hdr_take;
  logic        complete;
  logic [2:0]  need;
  logic [23:0] pb_asm;

  // Restart waits for the back end to drain; data waits near the image end or on a full queue
  assign in_i.ready = !full_i && !(status_i.busy && (in_i.func || status_i.near_end));
  assign accept     = in_i.valid && in_i.ready;

  assign need     = {1'b0, cfg_i.depth_mode} + 3'd1;
  assign complete = ({1'b0, bip_q} + 3'd1) >= need;
  assign hdr_take = cfg_i.run_coded && (hdr_q || (left_q == 8'd0));

  // Little-endian pixel assembly; the alpha byte is not kept
  always_comb begin
    pb_asm = (bip_q == 2'd0) ? 24'd0 : pb_q;
    case (bip_q)
      2'd0:    pb_asm[7:0]   = in_i.data_byte;
      2'd1:    pb_asm[15:8]  = in_i.data_byte;
      2'd2:    pb_asm[23:16] = in_i.data_byte;
      default: ;
    endcase
  end

  // Color decode of the finished pixel
  always_comb begin
    run_o = '0;
    case (cfg_i.depth_mode)
      tga_rle_pkg::Depth8: begin
        run_o.index_value = pb_asm[7:0];
      end
      tga_rle_pkg::Depth16: begin
        run_o.red   = {pb_asm[14:10], 3'b000};
        run_o.green = {pb_asm[9:5], 3'b000};
        run_o.blue  = {pb_asm[4:0], 3'b000};
      end
      default: begin
        run_o.blue  = pb_asm[7:0];
        run_o.green = pb_asm[15:8];
        run_o.red   = pb_asm[23:16];
      end
    endcase
    run_o.count = (cfg_i.run_coded && is_run_q) ? left_q : 8'd1;
  end

  // Packet and pixel state
  always_comb begin
    hdr_d     = hdr_q;
    is_run_d  = is_run_q;
    left_d    = left_q;
    bip_d     = bip_q;
    pb_d      = pb_q;
    push_o    = 1'b0;
    restart_o = 1'b0;
    if (accept) begin
      if (in_i.func) begin
        hdr_d     = 1'b1;
        is_run_d  = 1'b0;
        left_d    = 8'd0;
        bip_d     = 2'd0;
        pb_d      = 24'd0;
        restart_o = 1'b1;
      end else if (!status_i.done) begin
        if (hdr_take) begin
          is_run_d = in_i.data_byte[7];
          left_d   = {1'b0, in_i.data_byte[6:0]} + 8'd1;
          hdr_d    = 1'b0;
          bip_d    = 2'd0;
          pb_d     = 24'd0;
        end else if (!complete) begin
          pb_d  = pb_asm;
          bip_d = bip_q + 2'd1;
        end else begin
          bip_d  = 2'd0;
          pb_d   = 24'd0;
          push_o = 1'b1;
          if (cfg_i.run_coded) begin
            if (is_run_q) begin
              left_d = 8'd0;
              hdr_d  = 1'b1;
            end else begin
              left_d = left_q - 8'd1;
              if (left_q == 8'd1) begin
                hdr_d = 1'b1;
              end
            end
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hdr_q    <= 1'b1;
      is_run_q <= 1'b0;
      left_q   <= 8'd0;
      bip_q    <= 2'd0;
      pb_q     <= 24'd0;
    end else begin
      hdr_q    <= hdr_d;
      is_run_q <= is_run_d;
      left_q   <= left_d;
      bip_q    <= bip_d;
      pb_q     <= pb_d;
    end
  end

endmodule

// ===== rtl/core/tga_rle_fifo.sv =====
// Short run queue between front end and back end.
// Depends on tga_rle_pkg and the assertion macro header.
`include "tga_rle_pixel_decoder_core_assert.svh"

module tga_rle_fifo (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  tga_rle_pkg::run_t data_i,
  input  logic              pop_i,
  output tga_rle_pkg::run_t data_o,
  output logic              valid_o,
  output logic              full_o
);

  tga_rle_pkg::run_t                    mem_q [tga_rle_pkg::QueueDepth];
  logic [tga_rle_pkg::QPtrW-1:0]        wr_q, wr_d;
  logic [tga_rle_pkg::QPtrW-1:0]        rd_q, rd_d;
  logic [tga_rle_pkg::QCntW-1:0]        cnt_q, cnt_d;

  assign valid_o = (cnt_q != '0);
  assign full_o  = (cnt_q == tga_rle_pkg::QCntW'(tga_rle_pkg::QueueDepth));
  assign data_o  = mem_q[rd_q];

  // Pointer wrap and fill count
  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (push_i) begin
      wr_d = (wr_q == tga_rle_pkg::QPtrW'(tga_rle_pkg::QueueDepth - 1)) ? '0 : wr_q + 1'b1;
    end
    if (pop_i) begin
      rd_d = (rd_q == tga_rle_pkg::QPtrW'(tga_rle_pkg::QueueDepth - 1)) ? '0 : rd_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  // Entry storage
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= data_i;
    end
  end

  `TGA_RLE_ASSERT_IMP(a_fifo_no_overflow, push_i, !full_o, "run queue overflow")
  `TGA_RLE_ASSERT_IMP(a_fifo_no_underflow, pop_i, valid_o, "run queue underflow")
  `TGA_RLE_ASSERT_NXT(a_fifo_push_seen, push_i && !pop_i, valid_o, "pushed run not visible")

endmodule

// ===== rtl/core/tga_rle_back.sv =====
// Back end: splits pixel runs at line ends, tracks column and row, drives results.
// Depends on tga_rle_pkg, tga_rle_out_if and the assertion macro header.
`include "tga_rle_pixel_decoder_core_assert.svh"

module tga_rle_back (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  tga_rle_pkg::cfg_t          cfg_i,
  input  logic                       restart_i,
  input  logic                       run_valid_i,
  input  tga_rle_pkg::run_t          run_i,
  output logic                       pop_o,
  output tga_rle_pkg::back_status_t  status_o,
  tga_rle_out_if.source              out_o
);

  logic              act_q, act_d;
  tga_rle_pkg::run_t cur_q, cur_d;
  logic [15:0]       col_q, col_d;
  logic [15:0]       row_q, row_d;

  // Output register
  logic              ov_q, ov_d;
  tga_rle_pkg::run_t ores_q, ores_d;
  logic              oeol_q, oeol_d;
  logic              oeoi_q, oeoi_d;
  logic              olast_q, olast_d;

  logic [15:0] width;
  logic [15:0] room;
  logic [15:0] cnt16;
  logic [15:0] piece16;
  logic [7:0]  piece;
  logic [16:0] row_inc;
  logic [15:0] rows_left;
  logic        eol, eoi, fin, adv, fire;

  // Line piece of the current run
  assign width   = (cfg_i.line_width < 16'd3) ? 16'd3 : cfg_i.line_width;
  assign room    = (col_q < width) ? (width - col_q) : 16'd1;
  assign cnt16   = {8'd0, cur_q.count};
  assign piece16 = (cnt16 < room) ? cnt16 : room;
  assign piece   = piece16[7:0];
  assign eol     = (piece16 == room);
  assign row_inc = {1'b0, row_q} + 17'd1;
  assign eoi     = eol && (row_inc >= {1'b0, cfg_i.line_total});
  assign fin     = (cur_q.count == piece) || eoi;

  assign adv   = !ov_q || out_o.ready;
  assign fire  = act_q && adv;
  assign pop_o = run_valid_i && (!act_q || (fire && fin));

  // Status toward the front end
  assign rows_left         = cfg_i.line_total - row_q;
  assign status_o.busy     = act_q || run_valid_i;
  assign status_o.done     = (row_q >= cfg_i.line_total);
  assign status_o.near_end = status_o.done || (rows_left <= 16'(tga_rle_pkg::NearEndRows));

  always_comb begin
    act_d   = act_q;
    cur_d   = cur_q;
    col_d   = col_q;
    row_d   = row_q;
    ov_d    = ov_q;
    ores_d  = ores_q;
    oeol_d  = oeol_q;
    oeoi_d  = oeoi_q;
    olast_d = olast_q;

    if (out_o.ready) begin
      ov_d = 1'b0;
    end
    if (fire) begin
      ov_d         = 1'b1;
      ores_d       = cur_q;
      ores_d.count = piece;
      oeol_d       = eol;
      oeoi_d       = eoi;
      olast_d      = fin;
      cur_d.count  = cur_q.count - piece;
      if (eol) begin
        col_d = 16'd0;
        row_d = row_inc[15:0];
      end else begin
        col_d = col_q + piece16;
      end
      if (fin) begin
        act_d = 1'b0;
      end
    end
    if (pop_o) begin
      act_d = 1'b1;
      cur_d = run_i;
    end
    // Restart is only taken with nothing in flight
    if (restart_i) begin
      col_d = 16'd0;
      row_d = 16'd0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      act_q <= 1'b0;
      col_q <= 16'd0;
      row_q <= 16'd0;
      ov_q  <= 1'b0;
    end else begin
      act_q <= act_d;
      col_q <= col_d;
      row_q <= row_d;
      ov_q  <= ov_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cur_q   <= cur_d;
    ores_q  <= ores_d;
    oeol_q  <= oeol_d;
    oeoi_q  <= oeoi_d;
    olast_q <= olast_d;
  end

  assign out_o.valid        = ov_q;
  assign out_o.red          = ores_q.red;
  assign out_o.green        = ores_q.green;
  assign out_o.blue         = ores_q.blue;
  assign out_o.index_value  = ores_q.index_value;
  assign out_o.repeat_count = ores_q.count;
  assign out_o.end_of_line  = oeol_q;
  assign out_o.end_of_image = oeoi_q;
  assign out_o.last         = olast_q;

  `TGA_RLE_ASSERT_IMP(a_back_active_in_image, act_q, row_q < cfg_i.line_total,
                      "run in progress past the last line")
  `TGA_RLE_ASSERT_IMP(a_back_eoi_ends, ov_q && oeoi_q, olast_q && oeol_q,
                      "image end without line end or last flag")
  `TGA_RLE_ASSERT_NXT(a_back_run_continues, fire && !fin, act_q,
                      "unfinished run dropped")

endmodule

// ===== rtl/core/tga_rle_pixel_decoder_core.sv =====
// Targa pixel data decoder: one byte per cycle in, one pixel run per cycle out, when not stalled.
// A byte that completes a pixel passes the run queue, current run and output registers first.
// A run cut at k line ends gives up to k+1 results, one per ready cycle; two more runs queue behind.
// Input stalls while runs are in flight: for a restart, and within 132 lines of the image end.
// Reset clears packet state, counters, queue and output; registers return to defaults.
module tga_rle_pixel_decoder_core (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          cfg_we_i,
  input  logic [1:0]    cfg_index_i,
  input  logic [15:0]   cfg_data_i,
  tga_rle_in_if.sink    in_i,
  tga_rle_out_if.source out_o
);

  tga_rle_pkg::cfg_t         cfg_q;
  tga_rle_pkg::back_status_t status;
  tga_rle_pkg::run_t         push_run;
  tga_rle_pkg::run_t         head_run;
  logic                      push;
  logic                      pop;
  logic                      q_valid;
  logic                      q_full;
  logic                      restart;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= tga_rle_pkg::CfgReset;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        tga_rle_pkg::RegDepthMode: cfg_q.depth_mode <= tga_rle_pkg::depth_e'(cfg_data_i[1:0]);
        tga_rle_pkg::RegRunCoded:  cfg_q.run_coded  <= cfg_data_i[0];
        tga_rle_pkg::RegLineWidth: cfg_q.line_width <= cfg_data_i;
        tga_rle_pkg::RegLineTotal: cfg_q.line_total <= cfg_data_i;
        default: ;
      endcase
    end
  end

  tga_rle_front u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_i     (cfg_q),
    .status_i  (status),
    .full_i    (q_full),
    .in_i      (in_i),
    .push_o    (push),
    .run_o     (push_run),
    .restart_o (restart)
  );

  tga_rle_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (push_run),
    .pop_i   (pop),
    .data_o  (head_run),
    .valid_o (q_valid),
    .full_o  (q_full)
  );

  tga_rle_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .restart_i   (restart),
    .run_valid_i (q_valid),
    .run_i       (head_run),
    .pop_o       (pop),
    .status_o    (status),
    .out_o       (out_o)
  );

endmodule

// ===== verif/testbench.sv =====
// Self-checking bench for the Targa pixel data decoder core: byte stream in, pixel runs out.
// Depends on tga_rle_pkg and the tga_rle_in_if / tga_rle_out_if channel interfaces.
// A scoreboard class predicts every run and checks the output transfers in order.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned StallLimit  = 4000;  // cycles without any transfer
  localparam int unsigned DrainCycles = 64;    // pipeline drain plus a full 44-piece split
  localparam int unsigned HoldCycles  = 300;   // long receiver hold-off
  localparam int unsigned MaxPieces   = 44;
  localparam logic        FuncData    = 1'b0;
  localparam logic        FuncRestart = 1'b1;

  typedef struct {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [7:0] index_value;
    logic [7:0] repeat_count;
    logic       end_of_line;
    logic       end_of_image;
    logic       last;
  } pixel_run_t;

  // Predicts decoded runs and checks them against the output channel
  class pixel_run_scoreboard;
    tga_rle_pkg::depth_e depth;
    logic        run_coded;
    logic [15:0] line_width;
    logic [15:0] line_total;
    logic        in_header;
    logic        packet_is_run;
    logic [7:0]  pixels_left;
    logic [1:0]  byte_idx;
    logic [23:0] pixel_word;
    logic [15:0] column;
    logic [15:0] row;
    pixel_run_t  pending_runs[$];
    int unsigned n_checked;
    int unsigned n_errors;

    function new();
      depth      = tga_rle_pkg::Depth24;
      run_coded  = 1'b0;
      line_width = 16'd640;
      line_total = 16'd480;
      n_checked  = 0;
      n_errors   = 0;
      clear_stream();
    endfunction

    function void clear_stream();
      in_header     = 1'b1;
      packet_is_run = 1'b0;
      pixels_left   = '0;
      byte_idx      = '0;
      pixel_word    = '0;
      column        = '0;
      row           = '0;
    endfunction

    function void set_reg(logic [1:0] idx, logic [15:0] val);
      case (idx)
        tga_rle_pkg::RegDepthMode: depth = tga_rle_pkg::depth_e'(val[1:0]);
        tga_rle_pkg::RegRunCoded:  run_coded = val[0];
        tga_rle_pkg::RegLineWidth: line_width = val;
        tga_rle_pkg::RegLineTotal: line_total = val;
        default: ;
      endcase
    endfunction

    function bit image_done();
      return row >= line_total;
    endfunction

    function int unsigned outstanding();
      return pending_runs.size();
    endfunction

    // Cut a run of identical pixels at line ends and at the image end
    function int split_run(int unsigned count);
      int unsigned w;
      int unsigned room;
      int unsigned c;
      int          n;
      logic [15:0] v;
      pixel_run_t  piece;
      w = (line_width < 3) ? 3 : line_width;
      n = 0;
      piece.red         = '0;
      piece.green       = '0;
      piece.blue        = '0;
      piece.index_value = '0;
      v = pixel_word[15:0];
      case (depth)
        tga_rle_pkg::Depth8: piece.index_value = pixel_word[7:0];
        tga_rle_pkg::Depth16: begin
          piece.red   = {v[14:10], 3'b000};
          piece.green = {v[9:5], 3'b000};
          piece.blue  = {v[4:0], 3'b000};
        end
        default: begin
          piece.blue  = pixel_word[7:0];
          piece.green = pixel_word[15:8];
          piece.red   = pixel_word[23:16];
        end
      endcase
      while (count > 0 && row < line_total && n < MaxPieces) begin
        room  = (column < w) ? w - column : 1;
        c     = (count < room) ? count : room;
        count = count - c;
        piece.repeat_count = c[7:0];
        piece.end_of_line  = (c == room);
        piece.end_of_image = 1'b0;
        piece.last         = 1'b0;
        if (c == room) begin
          column = '0;
          row    = row + 16'd1;
          piece.end_of_image = (row >= line_total);
        end else begin
          column = column + c[15:0];
        end
        pending_runs.push_back(piece);
        n++;
      end
      return n;
    endfunction

    // Update on an accepted byte; returns runs expected, or -1 if the byte is dropped
    function int note_input(logic func, logic [7:0] data);
      int          n;
      int unsigned need;
      pixel_run_t  tail;
      need = int'(depth) + 1;
      n    = 0;
      if (func == FuncRestart) begin
        clear_stream();
        return 0;
      end
      if (row >= line_total) return -1;
      // packet header
      if (run_coded && (in_header || pixels_left == 0)) begin
        packet_is_run = data[7];
        pixels_left   = {1'b0, data[6:0]} + 8'd1;
        in_header     = 1'b0;
        byte_idx      = '0;
        pixel_word    = '0;
        return 0;
      end
      // pixel assembly, little-endian, alpha not kept
      if (byte_idx == 0) pixel_word = '0;
      if (byte_idx < 3) pixel_word = pixel_word | (24'(data) << (8 * byte_idx));
      if (int'(byte_idx) + 1 < need) begin
        byte_idx = byte_idx + 2'd1;
        return 0;
      end
      byte_idx = '0;
      if (!run_coded) begin
        n = split_run(1);
      end else if (packet_is_run) begin
        n = split_run(pixels_left);
        pixels_left = '0;
        in_header   = 1'b1;
      end else begin
        n = split_run(1);
        pixels_left = pixels_left - 8'd1;
        if (pixels_left == 0) in_header = 1'b1;
      end
      pixel_word = '0;
      if (n > 0) begin
        tail = pending_runs.pop_back();
        tail.last = 1'b1;
        pending_runs.push_back(tail);
      end
      return n;
    endfunction

    function void compare_field(string name, logic [7:0] want, logic [7:0] got);
      if (want !== got) begin
        $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
        n_errors++;
      end
    endfunction

    function void check_result(pixel_run_t got);
      pixel_run_t want;
      if (pending_runs.size() == 0) begin
        $display("%0t: unexpected run, actual rgb %h%h%h index %h count %0d eol %b eoi %b last %b",
                 $time, got.red, got.green, got.blue, got.index_value, got.repeat_count,
                 got.end_of_line, got.end_of_image, got.last);
        n_errors++;
        return;
      end
      want = pending_runs.pop_front();
      n_checked++;
      compare_field("red", want.red, got.red);
      compare_field("green", want.green, got.green);
      compare_field("blue", want.blue, got.blue);
      compare_field("index_value", want.index_value, got.index_value);
      compare_field("repeat_count", want.repeat_count, got.repeat_count);
      compare_field("end_of_line", want.end_of_line, got.end_of_line);
      compare_field("end_of_image", want.end_of_image, got.end_of_image);
      compare_field("last", want.last, got.last);
    endfunction
  endclass

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        cfg_we_i;
  logic [1:0]  cfg_index_i;
  logic [15:0] cfg_data_i;

  tga_rle_in_if  in_if ();
  tga_rle_out_if out_if ();

  tga_rle_pixel_decoder_core u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .in_i        (in_if),
    .out_o       (out_if)
  );

  pixel_run_scoreboard pixel_sb = new();

  int unsigned src_idle_pct = 0;
  int unsigned snk_idle_pct = 0;
  bit          hold_req     = 1'b0;
  int unsigned hold_left    = 0;
  int unsigned stall_cycles = 0;
  int unsigned n_bytes      = 0;
  int unsigned n_restarts   = 0;
  int unsigned n_fed        = 0;

  always #10 clk_i = ~clk_i;

  // Output side: check each run transfer, then pick ready for the next cycle
  always @(posedge clk_i) begin
    pixel_run_t got;
    if (out_if.valid && out_if.ready) begin
      got.red          = out_if.red;
      got.green        = out_if.green;
      got.blue         = out_if.blue;
      got.index_value  = out_if.index_value;
      got.repeat_count = out_if.repeat_count;
      got.end_of_line  = out_if.end_of_line;
      got.end_of_image = out_if.end_of_image;
      got.last         = out_if.last;
      pixel_sb.check_result(got);
    end
    if (hold_left > 0) begin
      hold_left--;
      out_if.ready <= 1'b0;
    end else if (hold_req) begin
      hold_req  = 1'b0;
      hold_left = HoldCycles - 1;
      out_if.ready <= 1'b0;
    end else begin
      out_if.ready <= ($urandom_range(99) >= snk_idle_pct);
    end
  end

  // Watchdog on cycles with no transfer on either channel
  always @(posedge clk_i) begin
    if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) begin
      stall_cycles = 0;
    end else begin
      stall_cycles = stall_cycles + 1;
      if (stall_cycles >= StallLimit) begin
        $display("simulation failed");
        $finish;
      end
    end
  end

  // One input transfer; valid stays high for a following item
  task automatic send_item(logic func, logic [7:0] data);
    int n;
    while ($urandom_range(99) < src_idle_pct) begin
      in_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    in_if.valid     <= 1'b1;
    in_if.func      <= func;
    in_if.data_byte <= data;
    do @(posedge clk_i); while (!in_if.ready);
    n = pixel_sb.note_input(func, data);
    n_bytes++;
    if (func == FuncRestart) n_restarts++;
    if (n >= 0) n_fed++;
  endtask

  task automatic restart();
    send_item(FuncRestart, 8'($urandom_range(255)));
  endtask

  task automatic send_pixel();
    repeat (int'(pixel_sb.depth) + 1) send_item(FuncData, 8'($urandom_range(255)));
  endtask

  // Well-formed packet: header then one pixel (run) or len+1 pixels (literal)
  task automatic send_packet();
    logic [7:0] hdr;
    hdr[7]   = 1'($urandom_range(1));
    hdr[6:0] = ($urandom_range(hdr[7] ? 7 : 31) == 0) ? 7'($urandom_range(127))
                                                       : 7'($urandom_range(3));
    send_item(FuncData, hdr);
    if (hdr[7]) send_pixel();
    else repeat (int'(hdr[6:0]) + 1) send_pixel();
  endtask

  task automatic write_reg(logic [1:0] idx, logic [15:0] val);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    @(posedge clk_i);
    pixel_sb.set_reg(idx, val);
  endtask

  task automatic configure(tga_rle_pkg::depth_e d, logic coded, logic [15:0] w,
                           logic [15:0] t);
    write_reg(tga_rle_pkg::RegDepthMode, 16'(d));
    write_reg(tga_rle_pkg::RegRunCoded, 16'(coded));
    write_reg(tga_rle_pkg::RegLineWidth, w);
    write_reg(tga_rle_pkg::RegLineTotal, t);
    cfg_we_i <= 1'b0;
  endtask

  // Wait until every predicted run is out and the core has gone quiet
  task automatic settle();
    in_if.valid <= 1'b0;
    while (pixel_sb.outstanding() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  // Mostly well-formed data, some stray bytes and restarts mid-packet
  task automatic random_phase(int unsigned n_items);
    int unsigned goal;
    int unsigned pick;
    goal = n_fed + n_items;
    if ($urandom_range(1)) restart();
    while (n_fed < goal) begin
      pick = $urandom_range(99);
      if (pixel_sb.image_done() && $urandom_range(3) != 0) restart();
      else if (pick < 6) restart();
      else if (pick < 16) send_item(FuncData, 8'($urandom_range(255)));
      else if (pixel_sb.run_coded) send_packet();
      else send_pixel();
    end
    settle();
  endtask

  initial begin
    in_if.valid     <= 1'b0;
    in_if.func      <= FuncData;
    in_if.data_byte <= '0;
    cfg_we_i        <= 1'b0;
    cfg_index_i     <= tga_rle_pkg::RegDepthMode;
    cfg_data_i      <= '0;
    rst_ni          <= 1'b0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset defaults: raw 24-bit
    send_item(FuncData, 8'h00);
    send_item(FuncData, 8'hFF);
    send_item(FuncData, 8'h80);
    settle();

    // 8-bit coded on a 3x2 image: longest run cut at the image end, then dropped byte
    configure(tga_rle_pkg::Depth8, 1'b1, 16'd3, 16'd2);
    restart();
    send_item(FuncData, 8'hFF);
    send_item(FuncData, 8'hAA);
    send_item(FuncData, 8'h55);
    restart();
    send_item(FuncData, 8'h00);
    send_item(FuncData, 8'h00);
    settle();

    // 16-bit coded on the widest and tallest image
    configure(tga_rle_pkg::Depth16, 1'b1, 16'hFFFF, 16'hFFFF);
    restart();
    send_item(FuncData, 8'h01);
    send_item(FuncData, 8'hFF);
    send_item(FuncData, 8'h7F);
    send_item(FuncData, 8'h00);
    send_item(FuncData, 8'h80);
    send_item(FuncData, 8'h81);
    send_item(FuncData, 8'h1F);
    send_item(FuncData, 8'h00);
    settle();

    // 32-bit raw, then a pixel left half done
    configure(tga_rle_pkg::Depth32, 1'b0, 16'hFFFF, 16'hFFFF);
    send_item(FuncData, 8'h01);
    send_item(FuncData, 8'h02);
    send_item(FuncData, 8'h03);
    send_item(FuncData, 8'h04);
    send_item(FuncData, 8'h11);
    send_item(FuncData, 8'h22);
    settle();

    // Depth drops mid-pixel and the line shrinks to its narrowest width
    configure(tga_rle_pkg::Depth8, 1'b0, 16'd3, 16'hFFFF);
    send_item(FuncData, 8'h33);
    send_item(FuncData, 8'h44);
    settle();

    // Random traffic, receiver mostly stalled, with one long hold-off
    src_idle_pct = 12;
    snk_idle_pct = 79;
    configure(tga_rle_pkg::Depth24, 1'b1, 16'd3, 16'hFFFF);
    hold_req = 1'b1;
    random_phase(80);
    configure(tga_rle_pkg::Depth32, 1'b0, 16'd5, 16'd4);
    random_phase(80);

    // Sender mostly idle
    src_idle_pct = 79;
    snk_idle_pct = 12;
    configure(tga_rle_pkg::Depth8, 1'b1, 16'd3, 16'd1);
    random_phase(80);
    configure(tga_rle_pkg::Depth16, 1'b1, 16'hFFFF, 16'hFFFF);
    random_phase(80);

    // Full rate on both sides
    src_idle_pct = 0;
    snk_idle_pct = 0;
    configure(tga_rle_pkg::Depth24, 1'b0, 16'd7, 16'd3);
    random_phase(80);
    configure(tga_rle_pkg::Depth16, 1'b1, 16'd4, 16'd200);
    random_phase(80);

    $display("Run covered %0d byte transfers (%0d restarts) and %0d checked pixel runs,",
             n_bytes, n_restarts, pixel_sb.n_checked);
    $display("all four depths, raw and coded data, line splits and image ends under stalls.");
    if (pixel_sb.n_errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+rtl/core
rtl/core/tga_rle_pkg.sv
rtl/core/tga_rle_if.sv
rtl/core/tga_rle_front.sv
rtl/core/tga_rle_fifo.sv
rtl/core/tga_rle_back.sv
rtl/core/tga_rle_pixel_decoder_core.sv
verif/testbench.sv
